FILE: src/bsa_pkg.sv
// Package with the types, sizes and helper functions of the banker's safety allocator.
`default_nettype none

package bsa_pkg;

  localparam int NUM_CUSTOMERS = 5;
  localparam int NUM_RESOURCES = 4;
  localparam int AMOUNT_BITS   = 8;
  localparam int WIDE_BITS     = 16;
  localparam int CUST_W        = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1;
  localparam int FIELD_AMOUNTS = 4;

  typedef enum logic [1:0] {
    KIND_LOAD_MAX = 2'd0,
    KIND_SET_POOL = 2'd1,
    KIND_REQUEST  = 2'd2,
    KIND_RELEASE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_REFUSED      = 2'd1,
    STAT_OVER_RELEASE = 2'd2,
    STAT_BAD_CUSTOMER = 2'd3
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] customer;
    logic [7:0] amount_0;
    logic [7:0] amount_1;
    logic [7:0] amount_2;
    logic [7:0] amount_3;
  } item_t;

  typedef struct packed {
    status_t status;
    logic    state_safe;
  } result_t;

  // Remaining need of one entry: the claim minus the holding, clamped at zero.
  function automatic logic [AMOUNT_BITS-1:0] renew_need(
    input logic [AMOUNT_BITS-1:0] claim,
    input logic [WIDE_BITS-1:0]   held
  );
    logic [WIDE_BITS-1:0] wide_claim;
    wide_claim = WIDE_BITS'(claim);
    if (wide_claim >= held) begin
      return AMOUNT_BITS'(wide_claim - held);
    end
    return '0;
  endfunction

  // Saturating add of an amount onto a wide counter.
  function automatic logic [WIDE_BITS-1:0] sat_add(
    input logic [WIDE_BITS-1:0] base,
    input logic [WIDE_BITS-1:0] addend
  );
    logic [WIDE_BITS:0] sum;
    sum = {1'b0, base} + {1'b0, addend};
    if (sum[WIDE_BITS]) begin
      return '1;
    end
    return sum[WIDE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/bankers_safety_allocator.sv
// Banker's deadlock-avoidance allocator with a row-serial safety checker.
//
//   Channel   Signals                Direction  Meaning
//   command   start, busy, item      in         one command beat, taken at start && !busy
//   result    done, result           out        one status beat, valid for one cycle
//
// An item passes the execute and seed states and then the safety check, which scans
// NUM_CUSTOMERS rows a pass, for at most NUM_CUSTOMERS passes. A refused request
// that failed the check adds a rollback state, a reseed and a second check. The rate
// is set by the single row compare-and-accumulate unit, which sees one customer row
// per cycle.
// Synchronous reset clears all allocation state to zero; busy stays high from
// the accepted beat until the cycle in which done is raised.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module bankers_safety_allocator (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire bsa_pkg::item_t  item,
  output logic                 busy,
  output logic                 done,
  output bsa_pkg::result_t     result
);
  import bsa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_INIT = 5'b00100,
    S_SCAN = 5'b01000,
    S_UNDO = 5'b10000
  } state_t;

  localparam logic [CUST_W-1:0] LAST_ROW = CUST_W'(NUM_CUSTOMERS - 1);

  state_t state;
  item_t  item_q;
  status_t status_q;
  logic   trial;
  logic   progress;
  logic [CUST_W-1:0] scan_idx;
  logic [NUM_CUSTOMERS-1:0] finished_mark;

  logic [WIDE_BITS-1:0]   pool_left    [NUM_RESOURCES];
  logic [WIDE_BITS-1:0]   work_pool    [NUM_RESOURCES];
  logic [AMOUNT_BITS-1:0] max_claim    [NUM_CUSTOMERS][NUM_RESOURCES];
  logic [WIDE_BITS-1:0]   held_amount  [NUM_CUSTOMERS][NUM_RESOURCES];
  logic [AMOUNT_BITS-1:0] still_needed [NUM_CUSTOMERS][NUM_RESOURCES];

  logic [7:0]             amount_all [FIELD_AMOUNTS];
  logic [AMOUNT_BITS-1:0] amt        [NUM_RESOURCES];
  logic [WIDE_BITS-1:0]   amt_wide   [NUM_RESOURCES];
  logic [CUST_W-1:0]      cust_idx;
  logic [CUST_W-1:0]      row_idx;
  logic                   cust_ok;

  logic [WIDE_BITS-1:0]   held_row [NUM_RESOURCES];
  logic [AMOUNT_BITS-1:0] need_row [NUM_RESOURCES];
  logic [WIDE_BITS:0]     hold_sum [NUM_RESOURCES];
  logic [NUM_RESOURCES-1:0] pool_fit, hold_fit, rel_fit, need_fit;
  logic req_ok, rel_ok, row_fits, prog_now, all_done;
  logic [NUM_CUSTOMERS-1:0] finished_next;

  // Amounts masked to the claim width, and the selected customer row.
  assign amount_all[0] = item_q.amount_0;
  assign amount_all[1] = item_q.amount_1;
  assign amount_all[2] = item_q.amount_2;
  assign amount_all[3] = item_q.amount_3;

  always_comb begin
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      amt[r]      = amount_all[r][AMOUNT_BITS-1:0];
      amt_wide[r] = WIDE_BITS'(amt[r]);
    end
  end

  assign cust_ok  = 32'(item_q.customer) < NUM_CUSTOMERS;
  assign cust_idx = item_q.customer[CUST_W-1:0];
  assign row_idx  = (state == S_SCAN) ? scan_idx : cust_idx;

  // Shared row unit: all resource lanes of one customer row in parallel.
  always_comb begin
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      held_row[r] = held_amount[row_idx][r];
      need_row[r] = still_needed[row_idx][r];
      hold_sum[r] = {1'b0, held_row[r]} + {1'b0, amt_wide[r]};
      pool_fit[r] = amt_wide[r] <= pool_left[r];
      hold_fit[r] = !hold_sum[r][WIDE_BITS];
      rel_fit[r]  = amt_wide[r] <= held_row[r];
      need_fit[r] = WIDE_BITS'(need_row[r]) <= work_pool[r];
    end
  end

  assign req_ok   = &pool_fit && &hold_fit;
  assign rel_ok   = &rel_fit;
  assign row_fits = !finished_mark[scan_idx] && &need_fit;
  assign prog_now = progress || row_fits;

  always_comb begin
    finished_next = finished_mark;
    if (row_fits) begin
      finished_next[scan_idx] = 1'b1;
    end
  end

  assign all_done = &finished_next;
  assign busy     = (state != S_IDLE);

  // Sequencer and allocation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      trial    <= 1'b0;
      progress <= 1'b0;
      scan_idx <= '0;
      finished_mark <= '0;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        pool_left[r] <= '0;
      end
      for (int c = 0; c < NUM_CUSTOMERS; c++) begin
        for (int r = 0; r < NUM_RESOURCES; r++) begin
          max_claim[c][r]    <= '0;
          held_amount[c][r]  <= '0;
          still_needed[c][r] <= '0;
        end
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item_q <= item;
            trial  <= 1'b0;
            state  <= S_EXEC;
          end
        end

        // Apply the command to the stored state.
        S_EXEC: begin
          status_q <= STAT_OK;
          state    <= S_INIT;
          if (item_q.kind == KIND_SET_POOL) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
              pool_left[r] <= amt_wide[r];
            end
          end else if (!cust_ok) begin
            status_q <= STAT_BAD_CUSTOMER;
          end else begin
            case (item_q.kind)
              KIND_LOAD_MAX: begin
                for (int r = 0; r < NUM_RESOURCES; r++) begin
                  max_claim[cust_idx][r]    <= amt[r];
                  held_amount[cust_idx][r]  <= '0;
                  still_needed[cust_idx][r] <= amt[r];
                end
              end
              KIND_REQUEST: begin
                if (req_ok) begin
                  trial <= 1'b1;
                  for (int r = 0; r < NUM_RESOURCES; r++) begin
                    pool_left[r]              <= pool_left[r] - amt_wide[r];
                    held_amount[cust_idx][r]  <= hold_sum[r][WIDE_BITS-1:0];
                    still_needed[cust_idx][r] <=
                      renew_need(max_claim[cust_idx][r], hold_sum[r][WIDE_BITS-1:0]);
                  end
                end else begin
                  status_q <= STAT_REFUSED;
                end
              end
              default: begin
                if (rel_ok) begin
                  for (int r = 0; r < NUM_RESOURCES; r++) begin
                    pool_left[r]              <= sat_add(pool_left[r], amt_wide[r]);
                    held_amount[cust_idx][r]  <= held_row[r] - amt_wide[r];
                    still_needed[cust_idx][r] <=
                      renew_need(max_claim[cust_idx][r], held_row[r] - amt_wide[r]);
                  end
                end else begin
                  status_q <= STAT_OVER_RELEASE;
                end
              end
            endcase
          end
        end

        // Seed the safety check from the free pool.
        S_INIT: begin
          for (int r = 0; r < NUM_RESOURCES; r++) begin
            work_pool[r] <= pool_left[r];
          end
          finished_mark <= '0;
          scan_idx      <= '0;
          progress      <= 1'b0;
          state         <= S_SCAN;
        end

        // One customer row per cycle; a pass ends at the last row.
        S_SCAN: begin
          finished_mark <= finished_next;
          if (row_fits) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
              work_pool[r] <= sat_add(work_pool[r], held_row[r]);
            end
          end
          if (scan_idx != LAST_ROW) begin
            scan_idx <= scan_idx + 1'b1;
            progress <= prog_now;
          end else if (!all_done && prog_now) begin
            scan_idx <= '0;
            progress <= 1'b0;
          end else if (trial && !all_done) begin
            status_q <= STAT_REFUSED;
            state    <= S_UNDO;
          end else begin
            done              <= 1'b1;
            result.status     <= status_q;
            result.state_safe <= all_done;
            state             <= S_IDLE;
          end
        end

        // Roll back a request whose state failed the check, then check again.
        S_UNDO: begin
          trial <= 1'b0;
          state <= S_INIT;
          for (int r = 0; r < NUM_RESOURCES; r++) begin
            pool_left[r]              <= sat_add(pool_left[r], amt_wide[r]);
            held_amount[cust_idx][r]  <= held_row[r] - amt_wide[r];
            still_needed[cust_idx][r] <=
              renew_need(max_claim[cust_idx][r], held_row[r] - amt_wide[r]);
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result beat closes the item, so the block is free in that cycle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while the sequencer is still busy");

  // An accepted command beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not start the sequencer");

  // Exactly one result per item: no two result beats back to back.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result beats in a row");

  // The sequencer only leaves idle on an accepted command.
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("sequencer started without a command beat");

  // A rollback only follows a granted trial request.
  a_undo_after_trial: assert property (@(posedge clk) disable iff (rst)
    state == S_UNDO |-> $past(trial) && item_q.kind == KIND_REQUEST)
    else $error("rollback without a trial grant");

endmodule

`default_nettype wire
